@@ rtl/stv_pkg.sv @@
// shared types, codes and constants of the speculative token verifier
package stv_pkg;

    localparam int TOKEN_BITS = 18;
    localparam int MAX_GROUP  = 48;
    localparam int GLEN_W     = 6;
    localparam int CNT_W      = 20;
    localparam int PROB_W     = 16;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 160;

    // decision codes
    localparam logic [1:0] DEC_ACCEPT  = 2'd0;
    localparam logic [1:0] DEC_REJECT  = 2'd1;
    localparam logic [1:0] DEC_GATED   = 2'd2;
    localparam logic [1:0] DEC_SAMPLED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_BASE_LEN   = 3'd0;
    localparam logic [2:0] REG_MIN_LEN    = 3'd1;
    localparam logic [2:0] REG_MAX_LEN    = 3'd2;
    localparam logic [2:0] REG_GATE_THR   = 3'd3;
    localparam logic [2:0] REG_RATIO      = 3'd4;
    localparam logic [2:0] REG_STREAM_LEN = 3'd5;

    // reset values; base, min and max length and ratio also fall back to them when set to zero
    localparam logic [GLEN_W-1:0] DEF_BASE_LEN   = 6'd8;
    localparam logic [GLEN_W-1:0] DEF_MIN_LEN    = 6'd2;
    localparam logic [GLEN_W-1:0] DEF_MAX_LEN    = 6'd12;
    localparam logic [PROB_W-1:0] DEF_GATE_THR   = 16'd45875;
    localparam logic [PROB_W-1:0] DEF_RATIO      = 16'd16384;
    localparam logic [CNT_W-1:0]  DEF_STREAM_LEN = 20'd1;

    // floor(x/5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2^19
    localparam logic [18:0] DIV5_MUL   = 19'd419431;
    localparam int          DIV5_SHIFT = 21;

    typedef struct packed {
        logic [GLEN_W-1:0] base_len;
        logic [GLEN_W-1:0] min_len;
        logic [GLEN_W-1:0] max_len;
        logic [PROB_W-1:0] gate_thr;
        logic [PROB_W-1:0] ratio;
        logic [CNT_W-1:0]  run_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            dec;
        logic [TOKEN_BITS-1:0] draft_token;
        logic [TOKEN_BITS-1:0] target_token;
        logic [PROB_W-1:0]     draft_prob;
        logic [PROB_W-1:0]     uncertainty;
        logic [PROB_W-1:0]     target_prob;
    } item_t;

    typedef struct packed {
        logic [1:0]            decision;
        logic [TOKEN_BITS-1:0] token_out;
        logic [PROB_W-1:0]     uncertainty_out;
        logic [PROB_W-1:0]     draft_prob_out;
        logic [PROB_W-1:0]     target_prob_out;
        logic [GLEN_W-1:0]     group_len_now;
        logic                  group_ends;
        logic                  last_of_run;
        logic [CNT_W-1:0]      accepted_total;
        logic [CNT_W-1:0]      rejected_total;
        logic [CNT_W-1:0]      gated_total;
        logic [CNT_W-1:0]      target_calls_total;
    } result_t;

endpackage

@@ rtl/speculative_token_verifier.sv @@
// a result is registered once its input has passed the queue, then group setup, then commit
// the back end takes one token pair at a time through a two-step sequence
//   (group setup, then commit; output back-pressure stalls the commit); a reject's sampled record drains meanwhile
// a two-entry queue lets the input side keep accepting while results wait
// reset: counters, group state and uncertainty average clear to zero,
//   configuration registers return to their defaults
module speculative_token_verifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [stv_pkg::CNT_W-1:0]        cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // draft_token, draft_prob, draft_uncertainty, target_token, target_prob, zero pad
    input  logic [stv_pkg::IN_DATA_W-1:0]    s_tdata,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // token_out, uncertainty_out, draft_prob_out, target_prob_out, group_len_now,
    // group_ends, accepted_total, rejected_total, gated_total, target_calls_total,
    // zero pad
    output logic [stv_pkg::OUT_DATA_W-1:0]   m_tdata,
    // decision
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    stv_pkg::cfg_t    cfg_reg;
    stv_pkg::item_t   front_item;
    stv_pkg::item_t   head_item;
    stv_pkg::result_t result;
    logic             q_full;
    logic             head_valid;
    logic             pop;
    logic             push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_len   <= stv_pkg::DEF_BASE_LEN;
            cfg_reg.min_len    <= stv_pkg::DEF_MIN_LEN;
            cfg_reg.max_len    <= stv_pkg::DEF_MAX_LEN;
            cfg_reg.gate_thr   <= stv_pkg::DEF_GATE_THR;
            cfg_reg.ratio      <= stv_pkg::DEF_RATIO;
            cfg_reg.run_len    <= stv_pkg::DEF_STREAM_LEN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                stv_pkg::REG_BASE_LEN:   cfg_reg.base_len   <= cfg_data[5:0];
                stv_pkg::REG_MIN_LEN:    cfg_reg.min_len    <= cfg_data[5:0];
                stv_pkg::REG_MAX_LEN:    cfg_reg.max_len    <= cfg_data[5:0];
                stv_pkg::REG_GATE_THR:   cfg_reg.gate_thr   <= cfg_data[15:0];
                stv_pkg::REG_RATIO:      cfg_reg.ratio      <= cfg_data[15:0];
                stv_pkg::REG_STREAM_LEN: cfg_reg.run_len    <= cfg_data;
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    stv_front u_front
    (
        .cfg   (cfg_reg),
        .tdata (s_tdata),
        .item  (front_item)
    );

    stv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    stv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    assign m_tuser = result.decision;
    assign m_tlast = result.last_of_run;
    assign m_tdata = {7'd0,
                      result.target_calls_total,
                      result.gated_total,
                      result.rejected_total,
                      result.accepted_total,
                      result.group_ends,
                      result.group_len_now,
                      result.target_prob_out,
                      result.draft_prob_out,
                      result.uncertainty_out,
                      result.token_out};

endmodule

@@ rtl/stv_front.sv @@
// front end: unpacks an input transaction and classifies it as gated, accept or reject
module stv_front
(
    input  stv_pkg::cfg_t                    cfg,
    input  logic [stv_pkg::IN_DATA_W-1:0]    tdata,
    output stv_pkg::item_t                   item
);

    logic [stv_pkg::TOKEN_BITS-1:0] draft_token;
    logic [stv_pkg::TOKEN_BITS-1:0] target_token;
    logic [stv_pkg::PROB_W-1:0]     draft_prob;
    logic [stv_pkg::PROB_W-1:0]     uncertainty;
    logic [stv_pkg::PROB_W-1:0]     target_prob;
    logic [stv_pkg::PROB_W-1:0]     ratio_eff;
    logic [31:0]                    need;
    logic [31:0]                    have;
    logic                           gated;
    logic                           pass;

    assign draft_token  = tdata[17:0];
    assign draft_prob   = tdata[33:18];
    assign uncertainty  = tdata[49:34];
    assign target_token = tdata[67:50];
    assign target_prob  = tdata[83:68];

    always_comb
    begin
        ratio_eff = (cfg.ratio == '0) ? stv_pkg::DEF_RATIO : cfg.ratio;
        need      = 32'(ratio_eff) * 32'(draft_prob);
        // target_prob in Q2.14 scale against ratio * draft_prob
        have      = {2'b00, target_prob, 14'd0};
        gated     = uncertainty > cfg.gate_thr;
        pass      = (draft_token == target_token) && (have >= need);

        item.draft_token  = draft_token;
        item.target_token = target_token;
        item.draft_prob   = draft_prob;
        item.uncertainty  = uncertainty;
        item.target_prob  = target_prob;
        if (gated)
        begin
            item.dec = stv_pkg::DEC_GATED;
        end
        else if (pass)
        begin
            item.dec = stv_pkg::DEC_ACCEPT;
        end
        else
        begin
            item.dec = stv_pkg::DEC_REJECT;
        end
    end

endmodule

@@ rtl/stv_queue.sv @@
// two-entry queue of classified items between front and back
module stv_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stv_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output stv_pkg::item_t head_item
);

    stv_pkg::item_t mem [2];
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

@@ rtl/stv_back.sv @@
// back end: group bookkeeping, counters, uncertainty average and result output
module stv_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  stv_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  stv_pkg::item_t   head_item,
    output logic             pop,
    input  logic             out_ready,
    output logic             out_valid,
    output stv_pkg::result_t out_result
);

    localparam logic PH_SETUP = 1'b0;
    localparam logic PH_EMIT  = 1'b1;

    logic                        phase_reg;
    logic                        phase_next;
    logic [stv_pkg::CNT_W-1:0]   stream_pos_reg;
    logic                        in_group_reg;
    logic [stv_pkg::GLEN_W-1:0]  group_len_reg;
    logic [stv_pkg::GLEN_W-1:0]  group_done_reg;
    logic [stv_pkg::PROB_W-1:0]  ema_reg;
    logic [stv_pkg::CNT_W-1:0]   acc_reg;
    logic [stv_pkg::CNT_W-1:0]   rej_reg;
    logic [stv_pkg::CNT_W-1:0]   gate_reg;

    stv_pkg::result_t            out_reg;
    logic                        out_valid_reg;
    stv_pkg::result_t            sec_reg;
    logic                        sec_valid_reg;

    // group length calculation
    logic [stv_pkg::GLEN_W-1:0]  base_eff;
    logic [stv_pkg::GLEN_W-1:0]  min_eff;
    logic [stv_pkg::GLEN_W-1:0]  max_eff;
    logic [16:0]                 one_minus;
    logic [23:0]                 rnd;
    logic [7:0]                  g_round;
    logic [7:0]                  g_lo;
    logic [7:0]                  g_hi;
    logic [7:0]                  g_cap;
    logic [stv_pkg::CNT_W-1:0]   left;
    logic [stv_pkg::CNT_W-1:0]   g_left;
    logic [stv_pkg::GLEN_W-1:0]  glen_calc;

    // commit step
    logic                        setup_go;
    logic                        emit_ok;
    logic                        emit_go;
    logic [stv_pkg::CNT_W:0]     pos_inc;
    logic                        stream_end;
    logic                        ends;
    logic                        is_rej;
    logic [stv_pkg::CNT_W-1:0]   acc_next;
    logic [stv_pkg::CNT_W-1:0]   rej_next;
    logic [stv_pkg::CNT_W-1:0]   gate_next;
    logic [18:0]                 ema_sum;
    logic [37:0]                 ema_prod;
    logic [stv_pkg::PROB_W-1:0]  ema_next;
    stv_pkg::result_t            r1;
    stv_pkg::result_t            r2;

    always_comb
    begin
        base_eff  = (cfg.base_len == '0) ? stv_pkg::DEF_BASE_LEN : cfg.base_len;
        min_eff   = (cfg.min_len == '0) ? stv_pkg::DEF_MIN_LEN : cfg.min_len;
        max_eff   = (cfg.max_len == '0) ? stv_pkg::DEF_MAX_LEN : cfg.max_len;
        if (min_eff > max_eff)
        begin
            min_eff = max_eff;
        end
        one_minus = 17'h10000 - 17'(ema_reg);
        rnd       = 24'(base_eff) * 24'(one_minus) + 24'h008000;
        g_round   = rnd[23:16];
        g_lo      = (g_round < 8'(min_eff)) ? 8'(min_eff) : g_round;
        g_hi      = (g_lo > 8'(max_eff)) ? 8'(max_eff) : g_lo;
        g_cap     = (g_hi > 8'(stv_pkg::MAX_GROUP)) ? 8'(max_eff) : g_hi;
        left      = (cfg.run_len > stream_pos_reg) ? (cfg.run_len - stream_pos_reg)
                                                    : 20'd1;
        g_left    = (20'(g_cap) > left) ? left : 20'(g_cap);
        glen_calc = g_left[stv_pkg::GLEN_W-1:0];
    end

    always_comb
    begin
        setup_go   = (phase_reg == PH_SETUP) && head_valid;
        emit_ok    = (!out_valid_reg || out_ready) && !sec_valid_reg;
        emit_go    = (phase_reg == PH_EMIT) && emit_ok;
        pop        = emit_go;

        is_rej     = (head_item.dec == stv_pkg::DEC_REJECT);
        acc_next   = acc_reg + 20'((head_item.dec == stv_pkg::DEC_ACCEPT) ? 1 : 0);
        rej_next   = rej_reg + 20'(is_rej ? 1 : 0);
        gate_next  = gate_reg + 20'((head_item.dec == stv_pkg::DEC_GATED) ? 1 : 0);
        pos_inc    = 21'(stream_pos_reg) + 21'd1;
        stream_end = pos_inc >= 21'(cfg.run_len);
        ends       = (head_item.dec != stv_pkg::DEC_ACCEPT)
                  || (group_done_reg >= group_len_reg) || stream_end;

        // (3*unc + 2*ema + 2) / 5 by reciprocal multiply
        ema_sum    = 19'({head_item.uncertainty, 1'b0}) + 19'(head_item.uncertainty)
                   + 19'({ema_reg, 1'b0}) + 19'd2;
        ema_prod   = 38'(ema_sum) * 38'(stv_pkg::DIV5_MUL);
        ema_next   = ema_prod[stv_pkg::DIV5_SHIFT+15:stv_pkg::DIV5_SHIFT];

        r1.decision           = head_item.dec;
        r1.token_out          = head_item.draft_token;
        r1.uncertainty_out    = head_item.uncertainty;
        r1.draft_prob_out     = head_item.draft_prob;
        r1.target_prob_out    = (head_item.dec == stv_pkg::DEC_GATED) ? '0
                                                                      : head_item.target_prob;
        r1.group_len_now      = group_len_reg;
        r1.group_ends         = ends;
        r1.last_of_run        = !is_rej;
        r1.accepted_total     = acc_next;
        r1.rejected_total     = rej_next;
        r1.gated_total        = gate_next;
        r1.target_calls_total = acc_next + rej_next;

        r2             = r1;
        r2.decision    = stv_pkg::DEC_SAMPLED;
        r2.token_out   = head_item.target_token;
        r2.last_of_run = 1'b1;

        phase_next = phase_reg;
        if (setup_go)
        begin
            phase_next = PH_EMIT;
        end
        else if (emit_go)
        begin
            phase_next = PH_SETUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SETUP;
            stream_pos_reg <= '0;
            in_group_reg   <= 1'b0;
            group_len_reg  <= '0;
            group_done_reg <= '0;
            ema_reg        <= '0;
            acc_reg        <= '0;
            rej_reg        <= '0;
            gate_reg       <= '0;
            out_valid_reg  <= 1'b0;
            sec_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;

            if (setup_go)
            begin
                if (!in_group_reg)
                begin
                    group_len_reg  <= glen_calc;
                    group_done_reg <= 6'd1;
                    in_group_reg   <= 1'b1;
                end
                else
                begin
                    group_done_reg <= group_done_reg + 6'd1;
                end
            end

            if (emit_go)
            begin
                if (stream_end)
                begin
                    stream_pos_reg <= '0;
                    in_group_reg   <= 1'b0;
                    group_len_reg  <= '0;
                    group_done_reg <= '0;
                    ema_reg        <= '0;
                    acc_reg        <= '0;
                    rej_reg        <= '0;
                    gate_reg       <= '0;
                end
                else
                begin
                    stream_pos_reg <= pos_inc[stv_pkg::CNT_W-1:0];
                    acc_reg        <= acc_next;
                    rej_reg        <= rej_next;
                    gate_reg       <= gate_next;
                    if (ends)
                    begin
                        in_group_reg <= 1'b0;
                        ema_reg      <= ema_next;
                    end
                end
            end

            // output register, fed by a new commit or by a waiting sampled record
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
                sec_valid_reg <= is_rej;
            end
            else if (sec_valid_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                sec_valid_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_reg <= r1;
            sec_reg <= r2;
        end
        else if (sec_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_reg <= sec_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench of the speculative token verifier: stream driver, result monitor, predictor
module tb;

    localparam int STALL_LIMIT = 2000;

    // indexes past the register map, ignored by the block
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [stv_pkg::TOKEN_BITS-1:0] draft_tok;
        logic [stv_pkg::PROB_W-1:0]     draft_prob;
        logic [stv_pkg::PROB_W-1:0]     unc;
        logic [stv_pkg::TOKEN_BITS-1:0] target_tok;
        logic [stv_pkg::PROB_W-1:0]     target_prob;
    } pair_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [2:0]                     cfg_index = '0;
    logic [stv_pkg::CNT_W-1:0]      cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [stv_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [stv_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;

    // shadow copy of the configuration registers
    logic [stv_pkg::GLEN_W-1:0] shadow_base = stv_pkg::DEF_BASE_LEN;
    logic [stv_pkg::GLEN_W-1:0] shadow_min = stv_pkg::DEF_MIN_LEN;
    logic [stv_pkg::GLEN_W-1:0] shadow_max = stv_pkg::DEF_MAX_LEN;
    logic [stv_pkg::PROB_W-1:0] shadow_thr = stv_pkg::DEF_GATE_THR;
    logic [stv_pkg::PROB_W-1:0] shadow_ratio = stv_pkg::DEF_RATIO;
    logic [stv_pkg::CNT_W-1:0]  shadow_slen = stv_pkg::DEF_STREAM_LEN;

    // predicted verifier state
    logic [stv_pkg::CNT_W-1:0]  st_pos = '0;
    logic                       grp_open = 1'b0;
    logic [stv_pkg::GLEN_W-1:0] grp_len = '0;
    logic [stv_pkg::GLEN_W-1:0] grp_done = '0;
    logic [stv_pkg::PROB_W-1:0] ema_unc = '0;
    logic [stv_pkg::CNT_W-1:0]  n_accept = '0;
    logic [stv_pkg::CNT_W-1:0]  n_reject = '0;
    logic [stv_pkg::CNT_W-1:0]  n_gate = '0;

    pair_t            pairs_to_send[$];
    stv_pkg::result_t results_due[$];
    pair_t            in_flight;
    stv_pkg::result_t seen;
    stv_pkg::result_t owed;
    bit               no_gaps = 1'b0;
    int               fail_count = 0;
    int               quiet_cycles = 0;

    speculative_token_verifier u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic logic [stv_pkg::IN_DATA_W-1:0] pack_pair(input pair_t p);
        return {4'b0, p.target_prob, p.target_tok, p.unc, p.draft_prob, p.draft_tok};
    endfunction

    function automatic stv_pkg::result_t unpack_result(
        input logic [stv_pkg::OUT_DATA_W-1:0] d,
        input logic [1:0] u, input logic l);
        stv_pkg::result_t r;
        r.decision           = u;
        r.token_out          = d[17:0];
        r.uncertainty_out    = d[33:18];
        r.draft_prob_out     = d[49:34];
        r.target_prob_out    = d[65:50];
        r.group_len_now      = d[71:66];
        r.group_ends         = d[72];
        r.last_of_run        = l;
        r.accepted_total     = d[92:73];
        r.rejected_total     = d[112:93];
        r.gated_total        = d[132:113];
        r.target_calls_total = d[152:133];
        return r;
    endfunction

    // length of a group opened now: base scaled by (1 - ema), then clamped
    function automatic logic [stv_pkg::GLEN_W-1:0] plan_group_len();
        longint unsigned b, mn, mx, g, left;
        b  = (shadow_base != '0) ? shadow_base : stv_pkg::DEF_BASE_LEN;
        mn = (shadow_min != '0) ? shadow_min : stv_pkg::DEF_MIN_LEN;
        mx = (shadow_max != '0) ? shadow_max : stv_pkg::DEF_MAX_LEN;
        if (mn > mx)
            mn = mx;
        g = (b * (65536 - ema_unc) + 32768) >> 16;
        if (g < mn)
            g = mn;
        if (g > mx)
            g = mx;
        if (g > stv_pkg::MAX_GROUP)
            g = mx;
        left = (shadow_slen > st_pos) ? shadow_slen - st_pos : 1;
        if (g > left)
            g = left;
        return g[stv_pkg::GLEN_W-1:0];
    endfunction

    task automatic judge_pair(input pair_t p);
        logic [stv_pkg::PROB_W-1:0] ratio_eff;
        logic [1:0]                 verdict;
        logic                       stream_end;
        logic                       closes;
        stv_pkg::result_t           r;
        ratio_eff = (shadow_ratio != '0) ? shadow_ratio : stv_pkg::DEF_RATIO;
        if (!grp_open)
        begin
            grp_len  = plan_group_len();
            grp_done = '0;
            grp_open = 1'b1;
        end
        grp_done = grp_done + 1'b1;

        if (p.unc > shadow_thr)
        begin
            verdict = stv_pkg::DEC_GATED;
            n_gate  = n_gate + 1'b1;
        end
        else if (p.draft_tok == p.target_tok &&
                 (longint'(p.target_prob) << 14) >= longint'(ratio_eff) * longint'(p.draft_prob))
        begin
            verdict  = stv_pkg::DEC_ACCEPT;
            n_accept = n_accept + 1'b1;
        end
        else
        begin
            verdict  = stv_pkg::DEC_REJECT;
            n_reject = n_reject + 1'b1;
        end

        stream_end = (32'(st_pos) + 32'd1) >= 32'(shadow_slen);
        closes = (verdict != stv_pkg::DEC_ACCEPT) || (grp_done >= grp_len) || stream_end;

        r.decision           = verdict;
        r.token_out          = p.draft_tok;
        r.uncertainty_out    = p.unc;
        r.draft_prob_out     = p.draft_prob;
        r.target_prob_out    = (verdict == stv_pkg::DEC_GATED) ? '0 : p.target_prob;
        r.group_len_now      = grp_len;
        r.group_ends         = closes;
        r.last_of_run        = (verdict != stv_pkg::DEC_REJECT);
        r.accepted_total     = n_accept;
        r.rejected_total     = n_reject;
        r.gated_total        = n_gate;
        r.target_calls_total = n_accept + n_reject;
        results_due.push_back(r);
        // a reject is followed by the target's own token
        if (verdict == stv_pkg::DEC_REJECT)
        begin
            r.decision    = stv_pkg::DEC_SAMPLED;
            r.token_out   = p.target_tok;
            r.last_of_run = 1'b1;
            results_due.push_back(r);
        end

        if (closes)
        begin
            grp_open = 1'b0;
            ema_unc  = 16'((3 * int'(p.unc) + 2 * int'(ema_unc) + 2) / 5);
        end
        st_pos = st_pos + 1'b1;
        if (stream_end)
        begin
            st_pos   = '0;
            grp_open = 1'b0;
            grp_len  = '0;
            grp_done = '0;
            ema_unc  = '0;
            n_accept = '0;
            n_reject = '0;
            n_gate   = '0;
        end
    endtask

    function automatic pair_t random_pair();
        pair_t       p;
        int unsigned pick;
        pick = $urandom_range(99);
        p.draft_tok   = 18'($urandom);
        p.draft_prob  = 16'($urandom);
        p.target_prob = (pick < 50) ? 16'($urandom_range(65535, p.draft_prob)) : 16'($urandom);
        p.target_tok  = (pick < 80) ? p.draft_tok : 18'($urandom);
        p.unc = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(shadow_thr, 0));
        if (pick == 99)
        begin
            p.draft_tok   = '1;
            p.target_tok  = '1;
            p.draft_prob  = '1;
            p.target_prob = '1;
        end
        return p;
    endfunction

    task automatic push_pair(input logic [stv_pkg::TOKEN_BITS-1:0] dt,
                             input logic [stv_pkg::PROB_W-1:0] dp,
                             input logic [stv_pkg::PROB_W-1:0] u,
                             input logic [stv_pkg::TOKEN_BITS-1:0] tt,
                             input logic [stv_pkg::PROB_W-1:0] tp);
        pairs_to_send.push_back(pair_t'{dt, dp, u, tt, tp});
    endtask

    // holds cfg_valid high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [stv_pkg::CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            stv_pkg::REG_BASE_LEN:   shadow_base  = val[stv_pkg::GLEN_W-1:0];
            stv_pkg::REG_MIN_LEN:    shadow_min   = val[stv_pkg::GLEN_W-1:0];
            stv_pkg::REG_MAX_LEN:    shadow_max   = val[stv_pkg::GLEN_W-1:0];
            stv_pkg::REG_GATE_THR:   shadow_thr   = val[stv_pkg::PROB_W-1:0];
            stv_pkg::REG_RATIO:      shadow_ratio = val[stv_pkg::PROB_W-1:0];
            stv_pkg::REG_STREAM_LEN: shadow_slen  = val;
            default:                 ;
        endcase
    endtask

    // checked between edges so the driver's and monitor's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pairs_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [stv_pkg::GLEN_W-1:0] b,
                             input logic [stv_pkg::GLEN_W-1:0] mn,
                             input logic [stv_pkg::GLEN_W-1:0] mx,
                             input logic [stv_pkg::PROB_W-1:0] thr,
                             input logic [stv_pkg::PROB_W-1:0] ratio,
                             input logic [stv_pkg::CNT_W-1:0] slen,
                             input int n, input bit steady);
        // junk in the unused upper data bits must be dropped
        write_reg(stv_pkg::REG_BASE_LEN, {14'($urandom), b});
        write_reg(stv_pkg::REG_MIN_LEN, {14'($urandom), mn});
        write_reg(stv_pkg::REG_MAX_LEN, {14'($urandom), mx});
        write_reg(stv_pkg::REG_GATE_THR, {4'($urandom), thr});
        write_reg(stv_pkg::REG_RATIO, {4'($urandom), ratio});
        write_reg(stv_pkg::REG_STREAM_LEN, slen);
        write_reg(REG_SPARE_LO, 20'($urandom));
        write_reg(REG_SPARE_HI, 20'($urandom));
        cfg_valid <= 1'b0;
        no_gaps = steady;
        repeat (n) pairs_to_send.push_back(random_pair());
        wait_idle();
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // driver: the block's state is predicted when a pair is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                judge_pair(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (pairs_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 6))
                begin
                    in_flight = pairs_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_pair(in_flight);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = unpack_result(m_tdata, m_tuser, m_tlast);
                if (results_due.size() == 0)
                begin
                    $display("%0t: result expected none, actual 0x%0h", $time, seen);
                    fail_count++;
                end
                else
                begin
                    owed = results_due.pop_front();
                    check_field("decision", owed.decision, seen.decision);
                    check_field("token_out", owed.token_out, seen.token_out);
                    check_field("uncertainty_out", owed.uncertainty_out, seen.uncertainty_out);
                    check_field("draft_prob_out", owed.draft_prob_out, seen.draft_prob_out);
                    check_field("target_prob_out", owed.target_prob_out, seen.target_prob_out);
                    check_field("group_len_now", owed.group_len_now, seen.group_len_now);
                    check_field("group_ends", owed.group_ends, seen.group_ends);
                    check_field("last_of_run", owed.last_of_run, seen.last_of_run);
                    check_field("accepted_total", owed.accepted_total, seen.accepted_total);
                    check_field("rejected_total", owed.rejected_total, seen.rejected_total);
                    check_field("gated_total", owed.gated_total, seen.gated_total);
                    check_field("target_calls_total", owed.target_calls_total,
                                seen.target_calls_total);
                end
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 6);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: every token is a stream of its own
        push_pair('0, '0, '0, '0, '0);
        push_pair('1, '1, '1, '1, '1);
        push_pair(18'h15555, 16'h8000, 16'd45875, 18'h15555, 16'h8000);
        push_pair(18'h2AAAA, 16'h4000, 16'd45876, 18'h2AAAA, 16'hFFFF);
        push_pair(18'h00001, 16'h1234, 16'h0100, 18'h00002, 16'hFFFF);
        wait_idle();

        write_reg(stv_pkg::REG_STREAM_LEN, 20'hFFFFF);
        cfg_valid <= 1'b0;
        // a run of accepts uses up a full group of eight
        for (int i = 0; i < 10; i++)
            push_pair(18'(i * 7 + 3), 16'h2000, '0, 18'(i * 7 + 3), 16'h2000);
        // probability ratio exactly at the limit, then one short of it
        push_pair(18'h00777, 16'd20000, 16'd100, 18'h00777, 16'd20000);
        push_pair(18'h00777, 16'd20000, 16'd100, 18'h00777, 16'd19999);
        // a high-uncertainty gate pulls the average up and shrinks the next group
        push_pair(18'h01234, 16'd500, 16'hFFFF, 18'h01234, 16'd500);
        for (int i = 0; i < 3; i++)
            push_pair(18'h0ABCD, 16'd3000, 16'd40000, 18'h0ABCD, 16'd9000);
        wait_idle();

        run_phase(6'd0, 6'd0, 6'd0, 16'hFFFF, 16'd0, 20'd30, 100, 1'b1);
        run_phase(6'd48, 6'd1, 6'd48, 16'd30000, 16'd8000, 20'hFFFFF, 100, 1'b0);
        run_phase(6'd63, 6'd63, 6'd63, 16'd0, 16'hFFFF, 20'd7, 60, 1'b0);
        run_phase(6'd20, 6'd40, 6'd10, 16'd50000, 16'd16384, 20'd0, 60, 1'b0);
        run_phase(6'd5, 6'd3, 6'd9, 16'd45875, 16'd20000, 20'd100, 140, 1'b0);
        run_phase(6'd12, 6'd2, 6'd30, 16'd40000, 16'd12000, 20'd13, 140, 1'b0);

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
